### sv/qfuf_pkg.sv
// package: shared types and codes for the quick-find union-find block
`timescale 1ns / 1ps
`default_nettype none

package qfuf_pkg;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_FIND  = 2'd0;
    localparam logic [1:0] CMD_CONN  = 2'd1;
    localparam logic [1:0] CMD_UNION = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_P_RANGE = 2'd1;
    localparam logic [1:0] ST_Q_RANGE = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDP,
        S_RDQ,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### sv/qfuf_ram.sv
// generic simple dual-port ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module qfuf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/quick_find_union_find.sv
// top level: quick-find union-find over a label table held in one ram
// find, connected and a union within one set read the label of p, then of q, then load the
//   result register; a range error loads it directly; a merging union first sweeps the table
// throughput: one item at a time; the next item is accepted once the result is registered
// reset and every size write start a clearing pass over element_count entries
//   (MAX_ELEMENTS after reset) that writes the identity table; no item is accepted during it
`timescale 1ns / 1ps
`default_nettype none

module quick_find_union_find #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input items
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: first_index, second_index (low bit up), zero padded to bytes
    input  wire  [((2*$clog2(MAX_ELEMENTS)+7)/8)*8-1:0] s_axis_tdata,
    // tuser: cmd
    input  wire  [1:0]             s_axis_tuser,
    // result items
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata: label, same_set, components, status (low bit up), zero padded to bytes
    output logic [(($clog2(MAX_ELEMENTS)+$clog2(MAX_ELEMENTS+1)+3+7)/8)*8-1:0] m_axis_tdata,
    // size register write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [$clog2(MAX_ELEMENTS+1)-1:0] i_cfg_data
);

    localparam int IW     = $clog2(MAX_ELEMENTS);
    localparam int CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int OUT_W  = IW + 1 + CW + 2;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    qfuf_pkg::t_state r_state, n_state;

    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_merge, n_merge;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_scan_v, n_scan_v;
    logic [IW-1:0]    r_scan_addr, n_scan_addr;
    logic [1:0]       r_cmd, n_cmd;
    logic [IW-1:0]    r_q, n_q;
    logic [IW-1:0]    r_lp, n_lp;
    logic [IW-1:0]    r_lq, n_lq;
    logic [1:0]       r_status, n_status;
    logic             r_m_valid, n_m_valid;
    logic [OUT_W-1:0] r_m_data, n_m_data;

    logic [IW-1:0]    in_p;
    logic [IW-1:0]    in_q;
    logic             in_acc;
    logic             cfg_acc;
    logic [CW-1:0]    cfg_size;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [IW-1:0]    mem_rdata;

    logic             scan_issue;
    logic [IW-1:0]    res_label;
    logic             res_same;
    logic [CW-1:0]    res_comp;

    // label table
    qfuf_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ELEMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // port decode, a pending size write holds off new items
    assign in_p          = s_axis_tdata[IW-1:0];
    assign in_q          = s_axis_tdata[2*IW-1:IW];
    assign s_axis_tready = (r_state == qfuf_pkg::S_IDLE) && !i_cfg_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DW'(r_m_data);

    // size clamp to 1..max
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = CW'(1);
        end else if (i_cfg_data > CW'(MAX_ELEMENTS)) begin
            cfg_size = CW'(MAX_ELEMENTS);
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // result fields
    always_comb begin
        res_comp = r_count - CW'(r_merge);
        if (r_status != qfuf_pkg::ST_OK) begin
            res_label = '0;
            res_same  = 1'b0;
        end else if (r_cmd == qfuf_pkg::CMD_UNION) begin
            res_label = r_lq;
            res_same  = (r_lp == r_lq);
        end else if (r_cmd == qfuf_pkg::CMD_CONN) begin
            res_label = r_lp;
            res_same  = (r_lp == r_lq);
        end else begin
            res_label = r_lp;
            res_same  = 1'b0;
        end
    end

    assign scan_issue = (r_idx < r_count);

    // sequencer: next state, table access and result load
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_merge     = r_merge;
        n_idx       = r_idx;
        n_scan_v    = r_scan_v;
        n_scan_addr = r_scan_addr;
        n_cmd       = r_cmd;
        n_q         = r_q;
        n_lp        = r_lp;
        n_lq        = r_lq;
        n_status    = r_status;
        n_m_data    = r_m_data;
        n_m_valid   = r_m_valid && !m_axis_tready;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[IW-1:0];
        mem_wdata   = r_idx[IW-1:0];
        mem_raddr   = in_p;

        case (r_state)
            qfuf_pkg::S_CLEAR: begin
                // identity fill, one entry a cycle
                mem_we = 1'b1;
                n_idx  = r_idx + CW'(1);
                if (r_idx == r_count - CW'(1)) begin
                    n_state = qfuf_pkg::S_IDLE;
                end
            end
            qfuf_pkg::S_IDLE: begin
                // take an item, check ranges, start the read of p
                if (in_acc) begin
                    n_cmd = (s_axis_tuser == qfuf_pkg::CMD_UNION ||
                             s_axis_tuser == qfuf_pkg::CMD_CONN) ?
                            s_axis_tuser : qfuf_pkg::CMD_FIND;
                    n_q   = in_q;
                    if (CW'(in_p) >= r_count) begin
                        n_status = qfuf_pkg::ST_P_RANGE;
                        n_state  = qfuf_pkg::S_DONE;
                    end else if ((s_axis_tuser == qfuf_pkg::CMD_UNION ||
                                  s_axis_tuser == qfuf_pkg::CMD_CONN) &&
                                 CW'(in_q) >= r_count) begin
                        n_status = qfuf_pkg::ST_Q_RANGE;
                        n_state  = qfuf_pkg::S_DONE;
                    end else begin
                        n_status = qfuf_pkg::ST_OK;
                        n_state  = qfuf_pkg::S_RDP;
                    end
                end
            end
            qfuf_pkg::S_RDP: begin
                n_lp      = mem_rdata;
                mem_raddr = r_q;
                n_state   = qfuf_pkg::S_RDQ;
            end
            qfuf_pkg::S_RDQ: begin
                n_lq = mem_rdata;
                if (r_cmd == qfuf_pkg::CMD_UNION && mem_rdata != r_lp) begin
                    n_state  = qfuf_pkg::S_SCAN;
                    n_idx    = '0;
                    n_scan_v = 1'b0;
                    n_merge  = r_merge + IW'(1);
                end else begin
                    n_state = qfuf_pkg::S_DONE;
                end
            end
            qfuf_pkg::S_SCAN: begin
                // read entry idx, rewrite the entry read in the previous cycle if it holds p's label
                mem_raddr   = r_idx[IW-1:0];
                n_scan_v    = scan_issue;
                n_scan_addr = r_idx[IW-1:0];
                if (scan_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_scan_v && mem_rdata == r_lp) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_scan_addr;
                    mem_wdata = r_lq;
                end
                if (!scan_issue && !r_scan_v) begin
                    n_state = qfuf_pkg::S_DONE;
                end
            end
            qfuf_pkg::S_DONE: begin
                // load the output register once it is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_data  = {r_status, res_comp, res_same, res_label};
                    n_m_valid = 1'b1;
                    n_state   = qfuf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qfuf_pkg::S_IDLE;
            end
        endcase

        // size write restarts the table
        if (cfg_acc) begin
            n_state  = qfuf_pkg::S_CLEAR;
            n_idx    = '0;
            n_count  = cfg_size;
            n_merge  = '0;
            n_scan_v = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qfuf_pkg::S_CLEAR;
            r_count   <= CW'(MAX_ELEMENTS);
            r_merge   <= '0;
            r_idx     <= '0;
            r_scan_v  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_merge   <= n_merge;
            r_idx     <= n_idx;
            r_scan_v  <= n_scan_v;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_cmd       <= n_cmd;
        r_q         <= n_q;
        r_lp        <= n_lp;
        r_lq        <= n_lq;
        r_status    <= n_status;
        r_m_data    <= n_m_data;
    end

    // no item is taken in the cycle after reset: the clearing pass runs first
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("item accepted before the table was cleared");

    // a size write always starts a clearing pass
    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_state == qfuf_pkg::S_CLEAR && r_merge == '0))
        else $error("size write did not restart the table");

    // the merge counter only steps by one or is cleared
    a_merge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(cfg_acc) |->
        (r_merge == $past(r_merge) || r_merge == IW'($past(r_merge) + IW'(1))))
        else $error("merge counter jumped");

    // at least one component always remains
    a_comp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == qfuf_pkg::S_DONE |-> res_comp != '0)
        else $error("component count reached zero");

endmodule

`default_nettype wire
